FILE: rtl/core/cwhb_pkg.sv
// ----------------------------------------------------------------------------
// cwhb_pkg
// Shared types and constants of the copy write hazard barrier tracker.
// ----------------------------------------------------------------------------
package cwhb_pkg;

    localparam int WINDOW_DEPTH = 128;
    localparam int SLICE_COUNT  = 3;
    localparam int ADDR_WIDTH   = 48;
    localparam int HANDLE_WIDTH = 32;

    localparam int LEN_W   = 41;
    localparam int END_W   = ((ADDR_WIDTH > LEN_W) ? ADDR_WIDTH : LEN_W) + 1;
    localparam int IDX_W   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);

    localparam logic [2:0] CMD_BUF_COPY = 3'd0;
    localparam logic [2:0] CMD_TEX_UPLD = 3'd1;
    localparam logic [2:0] CMD_TEX_CLR  = 3'd2;
    localparam logic [2:0] CMD_TEX_COPY = 3'd3;
    localparam logic [2:0] CMD_END      = 3'd4;

    localparam logic [2:0] REG_SPLIT_TARGETS = 3'd0;

    typedef struct packed {
        logic [2:0]  command;
        logic        has_slice;
        logic [2:0]  slice_index;
        logic [47:0] buffer_address;
        logic [40:0] byte_count;
        logic [31:0] dest_texture;
        logic [31:0] source_texture;
    } t_in_word;

    typedef struct packed {
        logic       target;
        logic       barrier_before;
        logic       is_summary;
        logic [1:0] used_mask;
        logic [7:0] buffer_slice_mask;
        logic [7:0] image_slice_mask;
    } t_out_word;

    // lookup travelling down the chain
    typedef struct packed {
        logic                    valid;
        logic                    tgt;
        logic [2:0]              cmd;
        logic [HANDLE_WIDTH-1:0] src;
        logic [HANDLE_WIDTH-1:0] dst;
        logic [ADDR_WIDTH-1:0]   rbeg;
        logic [END_W-1:0]        rend;
        logic [CNT_W-1:0]        tcnt;
        logic [CNT_W-1:0]        rcnt;
        logic                    hit;
    } t_query;

    // entry write broadcast to all cells
    typedef struct packed {
        logic                    tex_en;
        logic                    rng_en;
        logic                    tgt;
        logic [IDX_W-1:0]        idx;
        logic [HANDLE_WIDTH-1:0] handle;
        logic [ADDR_WIDTH-1:0]   rbeg;
        logic [END_W-1:0]        rend;
    } t_wr;

endpackage

FILE: rtl/core/cwhb_cell.sv
// ----------------------------------------------------------------------------
// cwhb_cell
// One window slot per target: compare a passing lookup, hand it onward.
// ----------------------------------------------------------------------------
module cwhb_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [cwhb_pkg::IDX_W-1:0] i_index,
    input  cwhb_pkg::t_query      i_q,
    input  cwhb_pkg::t_wr         i_wr,
    output cwhb_pkg::t_query      o_q
);
    import cwhb_pkg::*;

    logic [HANDLE_WIDTH-1:0] r_tex  [2];
    logic [ADDR_WIDTH-1:0]   r_rbeg [2];
    logic [END_W-1:0]        r_rend [2];
    t_query                  r_q;
    t_query                  n_q;
    logic                    tex_live;
    logic                    rng_live;
    logic                    tex_hit;
    logic                    rng_hit;

    always_comb begin
        tex_live = CNT_W'(i_index) < i_q.tcnt;
        rng_live = CNT_W'(i_index) < i_q.rcnt;
        tex_hit  = tex_live &&
                   (((i_q.cmd == CMD_TEX_COPY) && (r_tex[i_q.tgt] == i_q.src)) ||
                    ((i_q.cmd != CMD_BUF_COPY) && (r_tex[i_q.tgt] == i_q.dst)));
        rng_hit  = rng_live && (i_q.cmd == CMD_BUF_COPY) &&
                   (END_W'(i_q.rbeg) < r_rend[i_q.tgt]) &&
                   (END_W'(r_rbeg[i_q.tgt]) < i_q.rend);
        n_q      = i_q;
        n_q.hit  = i_q.hit | tex_hit | rng_hit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.valid <= 1'b0;
        end else begin
            r_q.valid <= i_q.valid;
        end
        r_q.tgt  <= n_q.tgt;
        r_q.cmd  <= n_q.cmd;
        r_q.src  <= n_q.src;
        r_q.dst  <= n_q.dst;
        r_q.rbeg <= n_q.rbeg;
        r_q.rend <= n_q.rend;
        r_q.tcnt <= n_q.tcnt;
        r_q.rcnt <= n_q.rcnt;
        r_q.hit  <= n_q.hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.tex_en && (i_wr.idx == i_index)) begin
            r_tex[i_wr.tgt] <= i_wr.handle;
        end
        if (i_wr.rng_en && (i_wr.idx == i_index)) begin
            r_rbeg[i_wr.tgt] <= i_wr.rbeg;
            r_rend[i_wr.tgt] <= i_wr.rend;
        end
    end

    assign o_q = r_q;

endmodule

FILE: rtl/core/copy_write_hazard_barrier_tracker_unit.sv
// ----------------------------------------------------------------------------
// copy_write_hazard_barrier_tracker_unit
// Decides per copy command whether a transfer barrier must precede it.
// ----------------------------------------------------------------------------
// A copy command (buffer copy, texture upload, clear or copy) is resolved
// by a lookup that walks the row of window cells one cell per clock, each cell
// holding one recorded handle and one recorded address range per target.
// An end-of-flush word yields a summary result; an unknown command yields
// no result. One word is in flight at a time; a new word is accepted as soon
// as the previous result sits in the output register, even if not yet taken.
// No clearing pass is needed after reset: window slots are only trusted
// below the per-target fill counts, which reset and end of flush zero.
module copy_write_hazard_barrier_tracker_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cwhb_pkg::t_in_word   i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cwhb_pkg::t_out_word  o_out_word
);
    import cwhb_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_WAIT = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]       r_state, n_state;
    logic             r_split;
    t_in_word         r_word;
    logic             r_tgt;
    logic             r_hazard;
    logic [CNT_W-1:0] r_tcnt [2];
    logic [CNT_W-1:0] r_rcnt [2];
    logic [7:0]       r_smask [2];
    logic [1:0]       r_used;
    logic             r_out_valid;
    t_out_word        r_out;
    t_query           r_inj;

    t_query           q [WINDOW_DEPTH+1];
    t_wr              wr;

    logic             in_acc;
    logic             out_free;
    logic             n_tgt;
    logic             is_buf;
    logic [63:0]      addr64;
    logic [63:0]      dst64;
    logic [ADDR_WIDTH-1:0] addr;
    logic [END_W-1:0]      rend;
    logic             full;
    logic [CNT_W-1:0] tc_base;
    logic [CNT_W-1:0] rc_base;
    logic             commit;

    // configuration port: register 0 holds split_targets
    assign pready = 1'b1;
    assign prdata = {31'd0, r_split};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split <= 1'b0;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SPLIT_TARGETS[0])) begin
            r_split <= pwdata[0];
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign commit     = (r_state == S_DONE) && out_free;

    // route: buffer copies go to the buffer target only in split mode
    assign n_tgt  = !(r_split && (i_in_word.command == CMD_BUF_COPY));
    assign is_buf = (r_word.command == CMD_BUF_COPY);

    // trim fields to the used address and handle widths
    assign addr64 = 64'(r_word.buffer_address);
    assign dst64  = 64'(r_word.dest_texture);
    assign addr   = addr64[ADDR_WIDTH-1:0];
    assign rend   = END_W'(addr) + END_W'(r_word.byte_count);

    // launch the lookup into the head of the cell row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inj.valid <= 1'b0;
        end else begin
            r_inj.valid <= in_acc && (i_in_word.command <= CMD_END) &&
                           (i_in_word.command != CMD_END);
        end
        r_inj.tgt  <= n_tgt;
        r_inj.cmd  <= i_in_word.command;
        r_inj.src  <= HANDLE_WIDTH'(i_in_word.source_texture);
        r_inj.dst  <= HANDLE_WIDTH'(i_in_word.dest_texture);
        r_inj.rbeg <= ADDR_WIDTH'(i_in_word.buffer_address);
        r_inj.rend <= END_W'(ADDR_WIDTH'(i_in_word.buffer_address)) +
                      END_W'(i_in_word.byte_count);
        r_inj.tcnt <= r_tcnt[n_tgt];
        r_inj.rcnt <= r_rcnt[n_tgt];
        r_inj.hit  <= 1'b0;
    end

    assign q[0] = r_inj;

    genvar gi;
    generate
        for (gi = 0; gi < WINDOW_DEPTH; gi++) begin : g_cell
            cwhb_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_index (IDX_W'(gi)),
                .i_q     (q[gi]),
                .i_wr    (wr),
                .o_q     (q[gi+1])
            );
        end
    endgenerate

    // window full, or any cell hit, flags the barrier; a barrier empties the target
    assign full    = (r_tcnt[r_tgt] >= CNT_W'(WINDOW_DEPTH)) ||
                     (r_rcnt[r_tgt] >= CNT_W'(WINDOW_DEPTH));
    assign tc_base = r_hazard ? '0 : r_tcnt[r_tgt];
    assign rc_base = r_hazard ? '0 : r_rcnt[r_tgt];

    always_comb begin
        wr.tgt    = r_tgt;
        wr.idx    = IDX_W'(is_buf ? rc_base : tc_base);
        wr.handle = dst64[HANDLE_WIDTH-1:0];
        wr.rbeg   = addr;
        wr.rend   = rend;
        wr.tex_en = commit && !r_word.command[2] && !is_buf &&
                    (tc_base < CNT_W'(WINDOW_DEPTH));
        wr.rng_en = commit && !r_word.command[2] && is_buf &&
                    (rc_base < CNT_W'(WINDOW_DEPTH));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_word.command <= CMD_END)) begin
                    n_state = (i_in_word.command == CMD_END) ? S_DONE : S_WAIT;
                end
            end
            S_WAIT: begin
                if (q[WINDOW_DEPTH].valid) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_word <= i_in_word;
            r_tgt  <= n_tgt;
        end
        if ((r_state == S_WAIT) && q[WINDOW_DEPTH].valid) begin
            r_hazard <= q[WINDOW_DEPTH].hit || full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tcnt[0]   <= '0;
            r_tcnt[1]   <= '0;
            r_rcnt[0]   <= '0;
            r_rcnt[1]   <= '0;
            r_smask[0]  <= '0;
            r_smask[1]  <= '0;
            r_used      <= '0;
        end else begin
            r_state <= n_state;
            if (commit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (commit) begin
                if (r_word.command == CMD_END) begin
                    // report usage, then clear everything
                    r_tcnt[0]  <= '0;
                    r_tcnt[1]  <= '0;
                    r_rcnt[0]  <= '0;
                    r_rcnt[1]  <= '0;
                    r_smask[0] <= '0;
                    r_smask[1] <= '0;
                    r_used     <= '0;
                end else begin
                    r_used[r_tgt] <= 1'b1;
                    if (r_word.has_slice && ({1'b0, r_word.slice_index} < 4'(SLICE_COUNT))) begin
                        r_smask[r_tgt] <= r_smask[r_tgt] | (8'd1 << r_word.slice_index);
                    end
                    if (is_buf) begin
                        r_tcnt[r_tgt] <= tc_base;
                        r_rcnt[r_tgt] <= (rc_base < CNT_W'(WINDOW_DEPTH)) ?
                                         rc_base + CNT_W'(1) : rc_base;
                    end else begin
                        r_rcnt[r_tgt] <= rc_base;
                        r_tcnt[r_tgt] <= (tc_base < CNT_W'(WINDOW_DEPTH)) ?
                                         tc_base + CNT_W'(1) : tc_base;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            if (r_word.command == CMD_END) begin
                r_out.target            <= 1'b0;
                r_out.barrier_before    <= 1'b0;
                r_out.is_summary        <= 1'b1;
                r_out.used_mask         <= r_used;
                r_out.buffer_slice_mask <= r_smask[0];
                r_out.image_slice_mask  <= r_smask[1];
            end else begin
                r_out.target            <= r_tgt;
                r_out.barrier_before    <= r_hazard;
                r_out.is_summary        <= 1'b0;
                r_out.used_mask         <= '0;
                r_out.buffer_slice_mask <= '0;
                r_out.image_slice_mask  <= '0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

FILE: verif/copy_write_hazard_barrier_tracker_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// copy_write_hazard_barrier_tracker_unit_tb
// Drives copy command words into the barrier tracker and checks every result
// word against a predictor of the per-target hazard windows, slice masks and
// usage flags. It runs under random source gaps and sink stalls, and under
// both routing settings.
// ----------------------------------------------------------------------------
module copy_write_hazard_barrier_tracker_unit_tb;
    import cwhb_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 2 * WINDOW_DEPTH + 20;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_word    i_in_word = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_word   o_out_word;

    copy_write_hazard_barrier_tracker_unit dut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state: one window pair, slice mask and used bit per target.
    logic [HANDLE_WIDTH-1:0] tex_window [2][WINDOW_DEPTH];
    logic [ADDR_WIDTH-1:0]   range_lo   [2][WINDOW_DEPTH];
    logic [END_W-1:0]        range_hi   [2][WINDOW_DEPTH];
    int                      tex_fill   [2];
    int                      range_fill [2];
    logic [7:0]              slices_read [2];
    logic [1:0]              targets_hit;
    logic                    split_mode;

    t_in_word  pending_words [$];
    t_out_word expected_results [$];
    int        fail_count;
    int        words_sent;
    int        results_seen;
    int        quiet_cycles;

    // Clear all flush state; fill counts alone gate window reads.
    function automatic void flush_windows();
        tex_fill    = '{0, 0};
        range_fill  = '{0, 0};
        slices_read = '{8'h00, 8'h00};
        targets_hit = 2'b00;
    endfunction

    // Append one word to the send queue.
    function automatic void queue_word(input t_in_word w);
        pending_words = {pending_words, w};
    endfunction

    // Work out the result of one command and advance the state. Return 0
    // for commands that produce no result.
    function automatic bit predict_barrier(input t_in_word w, output t_out_word r);
        int          t;
        bit          is_buf;
        bit          hazard;
        logic [END_W-1:0] stop;
        r = '0;
        if (w.command > CMD_END) return 0;
        if (w.command == CMD_END) begin
            r.is_summary        = 1'b1;
            r.used_mask         = targets_hit;
            r.buffer_slice_mask = slices_read[0];
            r.image_slice_mask  = slices_read[1];
            flush_windows();
            return 1;
        end
        is_buf = (w.command == CMD_BUF_COPY);
        t = (split_mode && is_buf) ? 0 : 1;
        targets_hit[t] = 1'b1;
        if (w.has_slice && w.slice_index < SLICE_COUNT)
            slices_read[t][w.slice_index] = 1'b1;
        stop = END_W'(w.buffer_address) + END_W'(w.byte_count);
        hazard = (tex_fill[t] >= WINDOW_DEPTH) || (range_fill[t] >= WINDOW_DEPTH);
        for (int i = 0; i < tex_fill[t]; i++) begin
            if (w.command == CMD_TEX_COPY && tex_window[t][i] == w.source_texture)
                hazard = 1;
            if (!is_buf && tex_window[t][i] == w.dest_texture)
                hazard = 1;
        end
        if (is_buf) begin
            for (int i = 0; i < range_fill[t]; i++)
                if (END_W'(w.buffer_address) < range_hi[t][i] &&
                    END_W'(range_lo[t][i]) < stop)
                    hazard = 1;
        end
        if (hazard) begin
            tex_fill[t]   = 0;
            range_fill[t] = 0;
        end
        if (is_buf) begin
            if (range_fill[t] < WINDOW_DEPTH) begin
                range_lo[t][range_fill[t]] = w.buffer_address;
                range_hi[t][range_fill[t]] = stop;
                range_fill[t]++;
            end
        end else if (tex_fill[t] < WINDOW_DEPTH) begin
            tex_window[t][tex_fill[t]] = w.dest_texture;
            tex_fill[t]++;
        end
        r.target         = t[0];
        r.barrier_before = hazard;
        return 1;
    endfunction

    // ---------------- driver: hold each word until it is taken ----------------
    int send_gap;
    always @(posedge i_clk) begin
        t_out_word r;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap   = 0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                if (predict_barrier(i_in_word, r)) expected_results = {expected_results, r};
                words_sent++;
                // mostly short gaps, a few long ones, and gap-free bursts
                if (words_sent % 300 < 80) send_gap = 0;
                else if ($urandom_range(0, 19) == 0) send_gap = $urandom_range(20, 150);
                else send_gap = $urandom_range(0, 3);
            end
            if (!i_in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_in_valid <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    i_in_word  <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor: check words, stall the sink ----------------
    int sink_hold;
    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            sink_hold   = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: %p", o_out_word);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    if (o_out_word.target !== e.target) begin
                        $error("target exp %0d got %0d", e.target, o_out_word.target);
                        fail_count++;
                    end
                    if (o_out_word.barrier_before !== e.barrier_before) begin
                        $error("barrier_before exp %0d got %0d",
                               e.barrier_before, o_out_word.barrier_before);
                        fail_count++;
                    end
                    if (o_out_word.is_summary !== e.is_summary) begin
                        $error("is_summary exp %0d got %0d", e.is_summary,
                               o_out_word.is_summary);
                        fail_count++;
                    end
                    if (o_out_word.used_mask !== e.used_mask) begin
                        $error("used_mask exp %0h got %0h", e.used_mask,
                               o_out_word.used_mask);
                        fail_count++;
                    end
                    if (o_out_word.buffer_slice_mask !== e.buffer_slice_mask) begin
                        $error("buffer_slice_mask exp %0h got %0h",
                               e.buffer_slice_mask, o_out_word.buffer_slice_mask);
                        fail_count++;
                    end
                    if (o_out_word.image_slice_mask !== e.image_slice_mask) begin
                        $error("image_slice_mask exp %0h got %0h",
                               e.image_slice_mask, o_out_word.image_slice_mask);
                        fail_count++;
                    end
                end
                // long hold-off twice so the block backs up and stalls its input
                if (results_seen == 250 || results_seen == 1100) sink_hold = 700;
                else if (results_seen % 300 < 80) sink_hold = 0;
                else if ($urandom_range(0, 19) == 0) sink_hold = $urandom_range(20, 150);
                else sink_hold = $urandom_range(0, 3);
            end
            if (sink_hold > 0) begin
                sink_hold--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    function automatic t_in_word make_word(input logic [2:0] cmd);
        t_in_word w;
        w.command        = cmd;
        w.has_slice      = 1'($urandom_range(0, 1));
        w.slice_index    = 3'($urandom_range(0, 7));
        w.buffer_address = 48'({$urandom, $urandom});
        w.byte_count     = 41'({$urandom, $urandom});
        w.dest_texture   = $urandom;
        w.source_texture = $urandom;
        return w;
    endfunction

    // Random word biased toward small handle and address pools for hits.
    function automatic t_in_word random_word();
        t_in_word w;
        int       pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) w = make_word(3'($urandom_range(5, 7)));
        else if (pick < 8) w = make_word(CMD_END);
        else if (pick < 45) w = make_word(CMD_BUF_COPY);
        else w = make_word(3'($urandom_range(CMD_TEX_UPLD, CMD_TEX_COPY)));
        if ($urandom_range(0, 9) != 0) begin
            w.dest_texture   = $urandom_range(0, 40);
            w.source_texture = $urandom_range(0, 40);
            w.buffer_address = 48'($urandom_range(0, 4095));
            w.byte_count     = 41'($urandom_range(0, 256));
        end else if ($urandom_range(0, 1)) begin
            w.byte_count = 41'h100_0000_0000;
        end else begin
            w.byte_count = {1'b0, w.byte_count[39:0]};
        end
        return w;
    endfunction

    // Wait until the block is idle, then program the routing register.
    task automatic set_split(input logic value);
        wait (pending_words.size() == 0 && !i_in_valid && expected_results.size() == 0);
        repeat (4) @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_SPLIT_TARGETS);
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        split_mode = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial begin
        t_in_word w;
        fail_count   = 0;
        words_sent   = 0;
        results_seen = 0;
        split_mode   = 1'b0;
        flush_windows();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every command, corner cases
        set_split(1'b1);
        w = make_word(CMD_BUF_COPY);
        w.buffer_address = '1; w.byte_count = 41'h100_0000_0000;
        w.has_slice = 1; w.slice_index = 0;
        queue_word(w);
        w.buffer_address = '0; w.byte_count = 41'd1; w.slice_index = 7;
        queue_word(w);
        w.byte_count = '0; w.buffer_address = 48'd0;  // zero length at an edge
        queue_word(w);
        w = make_word(CMD_TEX_UPLD);
        w.dest_texture = '1; w.has_slice = 1; w.slice_index = 2;
        queue_word(w);
        w = make_word(CMD_TEX_CLR);
        w.dest_texture = '0; w.has_slice = 0; w.slice_index = 1;
        queue_word(w);
        w = make_word(CMD_TEX_COPY);
        w.source_texture = '1; w.dest_texture = 32'd5; w.has_slice = 1;
        w.slice_index = 3;
        queue_word(w);
        w.source_texture = '0; w.dest_texture = 32'd5;
        queue_word(w);
        for (int c = 5; c <= 7; c++) queue_word(make_word(3'(c)));
        w = make_word(CMD_END);
        queue_word(w);
        queue_word(w);

        for (int ph = 0; ph < 4; ph++) begin
            set_split(ph[0]);
            // fill the handle window past its depth, then, in the first two phases, the range window
            for (int i = 0; i < WINDOW_DEPTH + 2; i++) begin
                w = make_word(CMD_TEX_UPLD);
                w.dest_texture = 32'(1000 + i);
                queue_word(w);
            end
            if (ph < 2) begin
                for (int i = 0; i < WINDOW_DEPTH + 2; i++) begin
                    w = make_word(CMD_BUF_COPY);
                    w.buffer_address = 48'(i * 16);
                    w.byte_count     = 41'd16;
                    queue_word(w);
                end
            end
            queue_word(make_word(CMD_END));
            for (int i = 0; i < 290; i++) queue_word(random_word());
        end
        set_split(1'b0);   // sender pause until all results are in, then end
        wait (pending_words.size() == 0 && !i_in_valid && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
